/* hw/rtl/bnhg_pkg.sv */
package bnhg_pkg;

  localparam int RUN_DEPTH_DEF = 16;
  localparam int INTF_W        = 16;
  localparam int ADDR_W        = 64;
  localparam int ROLE_W        = 2;
  localparam int ATTR_W        = 32;

  localparam logic [ROLE_W-1:0] ROLE_PRIMARY = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_BACKUP  = 2'd1;

  typedef struct packed {
    logic [INTF_W-1:0] intf;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic [ROLE_W-1:0] role;
    logic [ATTR_W-1:0] attr;
  } hop_t;

  localparam int HOP_W = $bits(hop_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_APPEND,
    ST_RD,
    ST_CHK,
    ST_LAST
  } state_t;

  typedef struct packed {
    logic cap;
    logic append;
    logic clear;
    logic idx_clr;
    logic rd;
    logic hold;
    logic push;
    logic push_final;
  } cmd_t;

  typedef struct packed {
    logic mismatch;
    logic count_zero;
    logic idx_done;
    logic kept;
    logic held_valid;
    logic out_free;
    logic pend_final;
  } sts_t;

endpackage

/* hw/rtl/bnhg_ram.sv */
module bnhg_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/bnhg_ctrl.sv */
module bnhg_ctrl
  import bnhg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   flush_final;
  logic   flush_final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      flush_final <= 1'b0;
    end else begin
      state       <= state_next;
      flush_final <= flush_final_next;
    end
  end

  always_comb begin
    state_next       = state;
    flush_final_next = flush_final;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sts.count_zero && sts.mismatch) begin
          flush_final_next = 1'b0;
          state_next       = ST_RD;
        end else begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (sts.pend_final) begin
          flush_final_next = 1'b1;
          state_next       = ST_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        state_next = sts.idx_done ? ST_LAST : ST_CHK;
      end
      ST_CHK: begin
        if (!sts.kept || !sts.held_valid || sts.out_free) begin
          state_next = ST_RD;
        end
      end
      ST_LAST: begin
        if (!sts.held_valid || sts.out_free) begin
          state_next = flush_final ? ST_IDLE : ST_APPEND;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      ST_DECIDE: begin
        cmd.idx_clr = 1'b1;
      end
      ST_APPEND: begin
        cmd.append  = 1'b1;
        cmd.idx_clr = 1'b1;
      end
      ST_RD: begin
        cmd.rd = !sts.idx_done;
      end
      ST_CHK: begin
        if (sts.kept) begin
          if (!sts.held_valid) begin
            cmd.hold = 1'b1;
          end else if (sts.out_free) begin
            cmd.hold = 1'b1;
            cmd.push = 1'b1;
          end
        end
      end
      ST_LAST: begin
        if (!sts.held_valid || sts.out_free) begin
          cmd.push       = sts.held_valid;
          cmd.push_final = flush_final;
          cmd.clear      = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/bnhg_dp.sv */
module bnhg_dp
  import bnhg_pkg::*;
#(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [INTF_W-1:0] intf_id,
  input  logic [ADDR_W-1:0] addr_hi,
  input  logic [ADDR_W-1:0] addr_lo,
  input  logic [ROLE_W-1:0] hop_role,
  input  logic [ATTR_W-1:0] attr_tag,
  input  logic              is_final,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [INTF_W-1:0] out_intf_id,
  output logic [ADDR_W-1:0] out_addr_hi,
  output logic [ADDR_W-1:0] out_addr_lo,
  output logic [ROLE_W-1:0] out_role,
  output logic [ATTR_W-1:0] out_attr_tag,
  output logic              out_final,
  output logic              group_overflow
);

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);

  hop_t              pend;
  logic              pend_final;
  logic [INTF_W-1:0] key_intf;
  logic [ADDR_W-1:0] key_hi;
  logic [ADDR_W-1:0] key_lo;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic              has_primary;
  logic              overflowed;
  hop_t              held;
  logic              held_valid;
  hop_t              rd_hop;
  logic [HOP_W-1:0]  rdata;
  logic              room;
  logic              wr_en;

  assign room   = count < CW'(RUN_DEPTH);
  assign wr_en  = cmd.append && room;
  assign rd_hop = hop_t'(rdata);

  bnhg_ram #(
    .WIDTH (HOP_W),
    .DEPTH (RUN_DEPTH),
    .ADDR_W(AW)
  ) u_run_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[AW-1:0]),
    .wdata(pend),
    .re   (cmd.rd),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      pend.intf  <= intf_id;
      pend.hi    <= addr_hi;
      pend.lo    <= addr_lo;
      pend.role  <= hop_role;
      pend.attr  <= attr_tag;
      pend_final <= is_final;
    end
    if (wr_en && count == '0) begin
      key_intf <= pend.intf;
      key_hi   <= pend.hi;
      key_lo   <= pend.lo;
    end
    if (cmd.hold) begin
      held <= rd_hop;
    end
    if (cmd.push) begin
      out_intf_id    <= held.intf;
      out_addr_hi    <= held.hi;
      out_addr_lo    <= held.lo;
      out_role       <= held.role;
      out_attr_tag   <= held.attr;
      out_final      <= cmd.push_final;
      group_overflow <= overflowed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      idx         <= '0;
      has_primary <= 1'b0;
      overflowed  <= 1'b0;
      held_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count       <= '0;
        has_primary <= 1'b0;
        overflowed  <= 1'b0;
      end else if (cmd.append) begin
        if (room) begin
          count <= count + 1'b1;
          if (pend.role == ROLE_PRIMARY) begin
            has_primary <= 1'b1;
          end
        end else begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.rd) begin
        idx <= idx + 1'b1;
      end
      if (cmd.hold) begin
        held_valid <= 1'b1;
      end else if (cmd.push) begin
        held_valid <= 1'b0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.mismatch   = (key_intf != pend.intf) || (key_hi != pend.hi) || (key_lo != pend.lo);
    sts.count_zero = count == '0;
    sts.idx_done   = idx == count;
    sts.kept       = !(has_primary && rd_hop.role == ROLE_BACKUP);
    sts.held_valid = held_valid;
    sts.out_free   = !out_valid || !out_stall;
    sts.pend_final = pend_final;
  end

endmodule

/* hw/rtl/backup_next_hop_group_filter.sv */
// Channel  Handshake            Payload
// in       in_valid/in_stall    intf_id addr_hi addr_lo hop_role attr_tag is_final
// out      out_valid/out_stall  out_intf_id out_addr_hi out_addr_lo out_role
//                               out_attr_tag out_final group_overflow
// An item that does not end a run is decided and appended before the next transfer.
// Ending a run starts a pass over the buffered hops; the run buffer has one read
// port, each entry is read, then kept or dropped, in its own read and check
// states, and a final read state and a last state close the pass.
// A set-ending item whose key also differs runs two such passes.
// Synchronous reset empties the run and the output register; buffer contents persist.
// A stalled output holds the pass at the next kept hop; input stalls meanwhile.
module backup_next_hop_group_filter
  import bnhg_pkg::*;
#(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [INTF_W-1:0] intf_id,
  input  logic [ADDR_W-1:0] addr_hi,
  input  logic [ADDR_W-1:0] addr_lo,
  input  logic [ROLE_W-1:0] hop_role,
  input  logic [ATTR_W-1:0] attr_tag,
  input  logic              is_final,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [INTF_W-1:0] out_intf_id,
  output logic [ADDR_W-1:0] out_addr_hi,
  output logic [ADDR_W-1:0] out_addr_lo,
  output logic [ROLE_W-1:0] out_role,
  output logic [ATTR_W-1:0] out_attr_tag,
  output logic              out_final,
  output logic              group_overflow
);

  cmd_t cmd;
  sts_t sts;

  bnhg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  bnhg_dp #(
    .RUN_DEPTH(RUN_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .intf_id       (intf_id),
    .addr_hi       (addr_hi),
    .addr_lo       (addr_lo),
    .hop_role      (hop_role),
    .attr_tag      (attr_tag),
    .is_final      (is_final),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_intf_id   (out_intf_id),
    .out_addr_hi   (out_addr_hi),
    .out_addr_lo   (out_addr_lo),
    .out_role      (out_role),
    .out_attr_tag  (out_attr_tag),
    .out_final     (out_final),
    .group_overflow(group_overflow)
  );

endmodule
